### src/pcpd_pkg.sv
// ----------------------------------------------------------------------------
// pcpd_pkg
// Shared widths, codes and state-entry types of the pose change
// persistence detector.
// ----------------------------------------------------------------------------
package pcpd_pkg;

    // field widths
    localparam int AXIS_BITS   = 16;
    localparam int PERIOD_BITS = 24;
    localparam int TOL_BITS    = 15;
    localparam int ELAPSED_BITS = 16;
    localparam int MODE_BITS   = 3;
    localparam int GROUP_BITS  = 3;
    localparam int STATE_BITS  = 2;
    localparam int CNT_BITS    = 2;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 24;

    // storage depths
    localparam int NUM_CHANNELS = 6;
    localparam int NUM_GROUPS   = 5;

    // channel codes carried in mode
    localparam logic [MODE_BITS-1:0] MODE_BODY_POS    = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_BODY_ORIENT = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_TORSO       = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_HEAD        = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_RIGHT_HAND  = 3'd4;
    localparam logic [MODE_BITS-1:0] MODE_LEFT_HAND   = 3'd5;

    // group change states
    localparam logic [STATE_BITS-1:0] CS_UNKNOWN   = 2'd0;
    localparam logic [STATE_BITS-1:0] CS_UNCHANGED = 2'd1;
    localparam logic [STATE_BITS-1:0] CS_CHANGED   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_BODY_POS_TOL    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BODY_ORIENT_TOL = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TORSO_TOL       = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HEAD_TOL        = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HAND_TOL        = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_ACTIVE      = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_IDLE        = 3'd6;

    // reset values of the configuration registers
    localparam logic [TOL_BITS-1:0]    RST_BODY_POS_TOL    = 15'd500;
    localparam logic [TOL_BITS-1:0]    RST_BODY_ORIENT_TOL = 15'd500;
    localparam logic [TOL_BITS-1:0]    RST_TORSO_TOL       = 15'd500;
    localparam logic [TOL_BITS-1:0]    RST_HEAD_TOL        = 15'd500;
    localparam logic [TOL_BITS-1:0]    RST_HAND_TOL        = 15'd300;
    localparam logic [PERIOD_BITS-1:0] RST_MIN_ACTIVE      = 24'd1000;
    localparam logic [PERIOD_BITS-1:0] RST_MIN_IDLE        = 24'd1000;

    // per-channel entry: warm-up count and last sample
    typedef struct packed {
        logic [CNT_BITS-1:0]         count;
        logic signed [AXIS_BITS-1:0] a;
        logic signed [AXIS_BITS-1:0] b;
        logic signed [AXIS_BITS-1:0] c;
    } chan_entry_t;

    // per-group entry: last verdict and both periods
    typedef struct packed {
        logic [STATE_BITS-1:0]  state;
        logic [PERIOD_BITS-1:0] active;
        logic [PERIOD_BITS-1:0] idle;
    } group_entry_t;

endpackage

### src/pcpd_if.sv
// ----------------------------------------------------------------------------
// pcpd_if
// Valid/ready channels of the detector: sample input, result output and
// configuration write.
// ----------------------------------------------------------------------------

// sample channel
interface pcpd_smp_if
    import pcpd_pkg::*;
;
    logic                        valid;
    logic                        ready;
    logic [MODE_BITS-1:0]        mode;
    logic signed [AXIS_BITS-1:0] axis_a;
    logic signed [AXIS_BITS-1:0] axis_b;
    logic signed [AXIS_BITS-1:0] axis_c;
    logic [ELAPSED_BITS-1:0]     elapsed_ms;

    modport source (output valid, mode, axis_a, axis_b, axis_c, elapsed_ms, input ready);
    modport sink   (input valid, mode, axis_a, axis_b, axis_c, elapsed_ms, output ready);
endinterface

// result channel
interface pcpd_res_if
    import pcpd_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [GROUP_BITS-1:0]  group;
    logic [STATE_BITS-1:0]  change_state;
    logic [PERIOD_BITS-1:0] active_period;
    logic [PERIOD_BITS-1:0] idle_period;
    logic                   is_active;
    logic                   is_idle;

    modport source (output valid, group, change_state, active_period, idle_period,
                    is_active, is_idle, input ready);
    modport sink   (input valid, group, change_state, active_period, idle_period,
                    is_active, is_idle, output ready);
endinterface

// configuration write channel
interface pcpd_cfg_if
    import pcpd_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### src/pcpd_ram.sv
// ----------------------------------------------------------------------------
// pcpd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pcpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port (read returns the old word)
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### src/pose_change_persistence_detector_core.sv
// ----------------------------------------------------------------------------
// pose_change_persistence_detector_core
// Per-channel pose change detection with per-group active/idle persistence.
// ----------------------------------------------------------------------------
// The block takes one sample item per clock and keeps up that rate as long as
// results are taken. An accepted item reads its channel entry and its group
// entry from two small RAMs at the accepting edge; in the next cycle the
// compare and period update happen. Write-back and the capture of the result
// in the output register follow when stage 1 moves on, which an item with a
// result does only while the output register has room. The read-modify-write
// loop through the RAMs is closed by a forwarding register for back-to-back
// items on the same channel or group. Body orientation samples and modes 6
// and 7 give no result.
// Storage needs no clearing pass: a valid bit per entry makes unwritten
// entries read as zero right after reset.
// ----------------------------------------------------------------------------
module pose_change_persistence_detector_core
    import pcpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    pcpd_cfg_if.sink   cfg,
    pcpd_smp_if.sink   smp,
    pcpd_res_if.source res
);

    localparam int CH_AW  = $clog2(NUM_CHANNELS);
    localparam int GRP_AW = $clog2(NUM_GROUPS);

    // configuration registers
    logic [TOL_BITS-1:0]    body_pos_tol_reg;
    logic [TOL_BITS-1:0]    body_orient_tol_reg;
    logic [TOL_BITS-1:0]    torso_tol_reg;
    logic [TOL_BITS-1:0]    head_tol_reg;
    logic [TOL_BITS-1:0]    hand_tol_reg;
    logic [PERIOD_BITS-1:0] min_active_reg;
    logic [PERIOD_BITS-1:0] min_idle_reg;

    // stage 1 (state read back, update in progress)
    logic                        s1_valid_reg;
    logic [MODE_BITS-1:0]        s1_mode_reg;
    logic signed [AXIS_BITS-1:0] s1_a_reg;
    logic signed [AXIS_BITS-1:0] s1_b_reg;
    logic signed [AXIS_BITS-1:0] s1_c_reg;
    logic [ELAPSED_BITS-1:0]     s1_elapsed_reg;
    logic [GRP_AW-1:0]           s1_grp_reg;
    logic                        s1_ch_vld_reg;
    logic                        s1_grp_vld_reg;

    // forwarding from the write-back of the previous item
    logic         fwd_ch_hit_reg;
    chan_entry_t  fwd_ch_data_reg;
    logic         fwd_grp_hit_reg;
    group_entry_t fwd_grp_data_reg;

    // entry valid bits and the body turn latch
    logic [NUM_CHANNELS-1:0] ch_vld_reg;
    logic [NUM_GROUPS-1:0]   grp_vld_reg;
    logic                    turn_latch_reg;
    logic                    turn_latch_next;

    // output register
    logic                   out_valid_reg;
    logic [GROUP_BITS-1:0]  out_group_reg;
    logic [STATE_BITS-1:0]  out_state_reg;
    logic [PERIOD_BITS-1:0] out_active_reg;
    logic [PERIOD_BITS-1:0] out_idle_reg;
    logic                   out_is_active_reg;
    logic                   out_is_idle_reg;

    // handshake and RAM ports
    logic         accept;
    logic         s1_adv;
    logic         s1_has_result;
    logic         out_free;
    logic [CH_AW-1:0]  rd_ch;
    logic [GRP_AW-1:0] rd_grp;
    logic [MODE_BITS-1:0] grp_of_mode;
    logic         ch_we;
    logic         grp_we;
    logic [CH_AW-1:0] ch_waddr;
    chan_entry_t  ch_wdata;
    group_entry_t grp_wdata;
    chan_entry_t  ch_rdata;
    group_entry_t grp_rdata;

    // stage 1 results
    chan_entry_t  ch_cur;
    group_entry_t grp_cur;
    logic         known;
    logic         changed;
    logic [TOL_BITS-1:0]    tol;
    logic [AXIS_BITS:0]     abs_diff [3];
    logic signed [AXIS_BITS:0] diff [3];
    logic [PERIOD_BITS:0]   sum_active;
    logic [PERIOD_BITS:0]   sum_idle;
    group_entry_t           grp_new;
    logic                   flag_active;
    logic                   flag_idle;

    // ------------------------------------------------------------------
    // configuration write port
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            body_pos_tol_reg    <= RST_BODY_POS_TOL;
            body_orient_tol_reg <= RST_BODY_ORIENT_TOL;
            torso_tol_reg       <= RST_TORSO_TOL;
            head_tol_reg        <= RST_HEAD_TOL;
            hand_tol_reg        <= RST_HAND_TOL;
            min_active_reg      <= RST_MIN_ACTIVE;
            min_idle_reg        <= RST_MIN_IDLE;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_BODY_POS_TOL:    body_pos_tol_reg    <= cfg.data[TOL_BITS-1:0];
                CFG_BODY_ORIENT_TOL: body_orient_tol_reg <= cfg.data[TOL_BITS-1:0];
                CFG_TORSO_TOL:       torso_tol_reg       <= cfg.data[TOL_BITS-1:0];
                CFG_HEAD_TOL:        head_tol_reg        <= cfg.data[TOL_BITS-1:0];
                CFG_HAND_TOL:        hand_tol_reg        <= cfg.data[TOL_BITS-1:0];
                CFG_MIN_ACTIVE:      min_active_reg      <= cfg.data[PERIOD_BITS-1:0];
                CFG_MIN_IDLE:        min_idle_reg        <= cfg.data[PERIOD_BITS-1:0];
                default:             ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // handshake: stage 1 moves on when its result has room or it has none
    assign out_free      = !out_valid_reg || res.ready;
    assign s1_has_result = (s1_mode_reg < MODE_BITS'(NUM_CHANNELS))
                           && (s1_mode_reg != MODE_BODY_ORIENT);
    assign s1_adv        = s1_valid_reg && (!s1_has_result || out_free);
    assign smp.ready     = !s1_valid_reg || s1_adv;
    assign accept        = smp.valid && smp.ready;

    // read addresses from the incoming item
    assign rd_ch       = smp.mode[CH_AW-1:0];
    assign grp_of_mode = (smp.mode == MODE_BODY_POS) ? '0 : smp.mode - 1'b1;
    assign rd_grp      = grp_of_mode[GRP_AW-1:0];

    // ------------------------------------------------------------------
    // state memories
    pcpd_ram #(
        .WIDTH ($bits(chan_entry_t)),
        .DEPTH (NUM_CHANNELS)
    ) u_chan_ram (
        .clk   (clk),
        .we    (ch_we),
        .waddr (ch_waddr),
        .wdata (ch_wdata),
        .re    (accept),
        .raddr (rd_ch),
        .rdata (ch_rdata)
    );

    pcpd_ram #(
        .WIDTH ($bits(group_entry_t)),
        .DEPTH (NUM_GROUPS)
    ) u_group_ram (
        .clk   (clk),
        .we    (grp_we),
        .waddr (s1_grp_reg),
        .wdata (grp_wdata),
        .re    (accept),
        .raddr (rd_grp),
        .rdata (grp_rdata)
    );

    // ------------------------------------------------------------------
    // stage 1 register, valid bits and forwarding capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            ch_vld_reg      <= '0;
            grp_vld_reg     <= '0;
            turn_latch_reg  <= 1'b0;
            fwd_ch_hit_reg  <= 1'b0;
            fwd_grp_hit_reg <= 1'b0;
            s1_ch_vld_reg   <= 1'b0;
            s1_grp_vld_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg    <= 1'b1;
                fwd_ch_hit_reg  <= ch_we && (ch_waddr == rd_ch);
                fwd_grp_hit_reg <= grp_we && (s1_grp_reg == rd_grp);
                s1_ch_vld_reg   <= (smp.mode < MODE_BITS'(NUM_CHANNELS)) && ch_vld_reg[rd_ch];
                s1_grp_vld_reg  <= (grp_of_mode < MODE_BITS'(NUM_GROUPS))
                                   && grp_vld_reg[rd_grp];
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (ch_we)
            begin
                ch_vld_reg[ch_waddr] <= 1'b1;
            end
            if (grp_we)
            begin
                grp_vld_reg[s1_grp_reg] <= 1'b1;
            end
            if (s1_adv)
            begin
                turn_latch_reg <= turn_latch_next;
            end
        end
    end

    // stage 1 payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_mode_reg      <= smp.mode;
            s1_a_reg         <= smp.axis_a;
            s1_b_reg         <= smp.axis_b;
            s1_c_reg         <= smp.axis_c;
            s1_elapsed_reg   <= smp.elapsed_ms;
            s1_grp_reg       <= rd_grp;
            fwd_ch_data_reg  <= ch_wdata;
            fwd_grp_data_reg <= grp_wdata;
        end
    end

    // ------------------------------------------------------------------
    // current entries: forwarded, stored, or zero when never written
    always_comb
    begin
        if (fwd_ch_hit_reg)
            ch_cur = fwd_ch_data_reg;
        else if (s1_ch_vld_reg)
            ch_cur = ch_rdata;
        else
            ch_cur = '0;

        if (fwd_grp_hit_reg)
            grp_cur = fwd_grp_data_reg;
        else if (s1_grp_vld_reg)
            grp_cur = grp_rdata;
        else
            grp_cur = '0;
    end

    // tolerance of the channel
    always_comb
    begin
        unique case (s1_mode_reg)
            MODE_BODY_POS:    tol = body_pos_tol_reg;
            MODE_BODY_ORIENT: tol = body_orient_tol_reg;
            MODE_TORSO:       tol = torso_tol_reg;
            MODE_HEAD:        tol = head_tol_reg;
            default:          tol = hand_tol_reg;
        endcase
    end

    // per-axis absolute difference and change verdict
    always_comb
    begin
        diff[0] = {s1_a_reg[AXIS_BITS-1], s1_a_reg} - {ch_cur.a[AXIS_BITS-1], ch_cur.a};
        diff[1] = {s1_b_reg[AXIS_BITS-1], s1_b_reg} - {ch_cur.b[AXIS_BITS-1], ch_cur.b};
        diff[2] = {s1_c_reg[AXIS_BITS-1], s1_c_reg} - {ch_cur.c[AXIS_BITS-1], ch_cur.c};
        changed = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            abs_diff[i] = diff[i][AXIS_BITS] ? (AXIS_BITS+1)'(-diff[i])
                                             : (AXIS_BITS+1)'(diff[i]);
            if (abs_diff[i] >= (AXIS_BITS+1)'(tol))
                changed = 1'b1;
        end
    end

    assign known = ch_cur.count[1];

    // latch update: body orientation sets, torso consumes
    always_comb
    begin
        turn_latch_next = turn_latch_reg;
        if (s1_mode_reg == MODE_BODY_ORIENT && known && changed)
            turn_latch_next = 1'b1;
        else if (s1_mode_reg == MODE_TORSO)
            turn_latch_next = 1'b0;
    end

    // group update with saturating periods
    always_comb
    begin
        logic chg;
        chg = changed || ((s1_mode_reg == MODE_TORSO) && turn_latch_reg);
        sum_active = {1'b0, grp_cur.active} + (PERIOD_BITS+1)'(s1_elapsed_reg);
        sum_idle   = {1'b0, grp_cur.idle} + (PERIOD_BITS+1)'(s1_elapsed_reg);
        grp_new     = '0;
        flag_active = 1'b0;
        flag_idle   = 1'b0;
        if (known)
        begin
            if (chg)
            begin
                grp_new.state = CS_CHANGED;
                if (grp_cur.state == CS_CHANGED)
                    grp_new.active = sum_active[PERIOD_BITS] ? '1
                                                             : sum_active[PERIOD_BITS-1:0];
                flag_active = (grp_new.active >= min_active_reg);
            end
            else
            begin
                grp_new.state = CS_UNCHANGED;
                if (grp_cur.state == CS_UNCHANGED)
                    grp_new.idle = sum_idle[PERIOD_BITS] ? '1 : sum_idle[PERIOD_BITS-1:0];
                flag_idle = (grp_new.idle >= min_idle_reg);
            end
        end
    end

    // write-back: sample and warm-up count, group entry
    always_comb
    begin
        ch_wdata.a     = s1_a_reg;
        ch_wdata.b     = s1_b_reg;
        ch_wdata.c     = s1_c_reg;
        ch_wdata.count = known ? ch_cur.count : ch_cur.count + 1'b1;
    end

    assign ch_waddr  = s1_mode_reg[CH_AW-1:0];
    assign ch_we     = s1_adv && (s1_mode_reg < MODE_BITS'(NUM_CHANNELS));
    assign grp_we    = s1_adv && s1_has_result;
    assign grp_wdata = grp_new;

    // ------------------------------------------------------------------
    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (grp_we)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (grp_we)
        begin
            out_group_reg     <= GROUP_BITS'(s1_grp_reg);
            out_state_reg     <= grp_new.state;
            out_active_reg    <= grp_new.active;
            out_idle_reg      <= grp_new.idle;
            out_is_active_reg <= flag_active;
            out_is_idle_reg   <= flag_idle;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.group         = out_group_reg;
    assign res.change_state  = out_state_reg;
    assign res.active_period = out_active_reg;
    assign res.idle_period   = out_idle_reg;
    assign res.is_active     = out_is_active_reg;
    assign res.is_idle       = out_is_idle_reg;

    // ------------------------------------------------------------------
    // assertions

    // an unknown verdict carries zero periods and no flags
    a_unknown_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_state_reg == CS_UNKNOWN) |->
        (out_active_reg == '0 && out_idle_reg == '0 && !out_is_active_reg && !out_is_idle_reg))
        else $error("unknown result with nonzero period or flag");

    // active and idle are never flagged together
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_is_active_reg && out_is_idle_reg))
        else $error("active and idle flagged together");

    // body orientation never writes a group entry
    a_no_orient_group_write: assert property (@(posedge clk) disable iff (!rst_n)
        grp_we |-> (s1_mode_reg != MODE_BODY_ORIENT))
        else $error("group write from body orientation item");

    // input stalls only while stage 1 holds an item
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !smp.ready |-> (s1_valid_reg && out_valid_reg && !res.ready))
        else $error("input stalled without a blocked result");

    // a written channel entry is marked valid at the next edge
    a_valid_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        ch_we |=> ch_vld_reg[$past(ch_waddr)])
        else $error("channel entry not marked valid after write");

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pose change persistence detector. A directed
// table covers warm-up, tolerance boundaries, ignored modes and the body turn
// latch. Random phases follow: they reprogram the tolerances and minimum
// periods, and they vary sender gaps and receiver stalls. One phase holds the
// result side off long enough to back the block up. Another runs long enough
// to saturate the active period counter. Every result item is compared field
// by field with its typed row, else a predictor with its own block state copy.
// ----------------------------------------------------------------------------
module tb;
    import pcpd_pkg::*;

    // group codes of a result item
    localparam logic [GROUP_BITS-1:0] GRP_BODY       = 3'd0;
    localparam logic [GROUP_BITS-1:0] GRP_TORSO      = 3'd1;
    localparam logic [GROUP_BITS-1:0] GRP_HEAD       = 3'd2;
    localparam logic [GROUP_BITS-1:0] GRP_RIGHT_HAND = 3'd3;
    localparam logic [GROUP_BITS-1:0] GRP_LEFT_HAND  = 3'd4;

    // modes the block ignores
    localparam logic [MODE_BITS-1:0] MODE_UNUSED_LO = 3'd6;
    localparam logic [MODE_BITS-1:0] MODE_UNUSED_HI = 3'd7;

    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 4000;
    localparam int DRAIN_TAIL  = 8;
    localparam int SAT_ROUNDS  = 270;

    typedef struct packed {
        logic [MODE_BITS-1:0]        mode;
        logic signed [AXIS_BITS-1:0] a;
        logic signed [AXIS_BITS-1:0] b;
        logic signed [AXIS_BITS-1:0] c;
        logic [ELAPSED_BITS-1:0]     elapsed;
    } pose_sample_t;

    typedef struct packed {
        logic [GROUP_BITS-1:0]  group;
        logic [STATE_BITS-1:0]  change_state;
        logic [PERIOD_BITS-1:0] active_period;
        logic [PERIOD_BITS-1:0] idle_period;
        logic                   is_active;
        logic                   is_idle;
    } pose_result_t;

    // one directed item; typed rows carry the result read off by hand
    typedef struct packed {
        logic [MODE_BITS-1:0]        mode;
        logic signed [AXIS_BITS-1:0] a;
        logic signed [AXIS_BITS-1:0] b;
        logic signed [AXIS_BITS-1:0] c;
        logic [ELAPSED_BITS-1:0]     elapsed;
        logic                        typed;
        logic [GROUP_BITS-1:0]       group;
        logic [STATE_BITS-1:0]       cs;
        logic [PERIOD_BITS-1:0]      act;
        logic [PERIOD_BITS-1:0]      idl;
        logic                        ia;
        logic                        ii;
    } dir_row_t;

    // default settings: tolerance 500, hand 300, both minimums 1000
    dir_row_t dir_rows [0:24] = '{
        // body position: warm-up, full-scale swing, idle build-up, boundary
        '{MODE_BODY_POS, 16'sh7FFF, 16'sh8000, 16'sh0000, 16'hFFFF,
          1'b1, GRP_BODY, CS_UNKNOWN, 24'd0, 24'd0, 1'b0, 1'b0},
        '{MODE_BODY_POS, 16'sh7FFF, 16'sh8000, 16'sh0000, 16'h0000,
          1'b1, GRP_BODY, CS_UNKNOWN, 24'd0, 24'd0, 1'b0, 1'b0},
        '{MODE_BODY_POS, 16'sh8000, 16'sh7FFF, -16'sd1, 16'hFFFF,
          1'b1, GRP_BODY, CS_CHANGED, 24'd0, 24'd0, 1'b0, 1'b0},
        '{MODE_BODY_POS, 16'sh8000, 16'sh7FFF, -16'sd1, 16'hFFFF,
          1'b1, GRP_BODY, CS_UNCHANGED, 24'd0, 24'd0, 1'b0, 1'b0},
        '{MODE_BODY_POS, 16'sh8000, 16'sh7FFF, -16'sd1, 16'hFFFF,
          1'b1, GRP_BODY, CS_UNCHANGED, 24'd0, 24'd65535, 1'b0, 1'b1},
        '{MODE_BODY_POS, -16'sd32269, 16'sh7FFF, -16'sd1, 16'h0000,
          1'b1, GRP_BODY, CS_UNCHANGED, 24'd0, 24'd65535, 1'b0, 1'b1},
        '{MODE_BODY_POS, -16'sd31769, 16'sh7FFF, -16'sd1, 16'd7,
          1'b1, GRP_BODY, CS_CHANGED, 24'd0, 24'd0, 1'b0, 1'b0},
        // unused modes
        '{MODE_UNUSED_LO, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'hFFFF,
          1'b0, GRP_BODY, CS_UNKNOWN, 24'd0, 24'd0, 1'b0, 1'b0},
        '{MODE_UNUSED_HI, 16'sh8000, 16'sh8000, 16'sh8000, 16'h0000,
          1'b0, GRP_BODY, CS_UNKNOWN, 24'd0, 24'd0, 1'b0, 1'b0},
        // body turn feeding the torso
        '{MODE_BODY_ORIENT, 16'sd1000, 16'sd0, 16'sd0, 16'd10,
          1'b0, GRP_BODY, CS_UNKNOWN, 24'd0, 24'd0, 1'b0, 1'b0},
        '{MODE_BODY_ORIENT, 16'sd1000, 16'sd0, 16'sd0, 16'd10,
          1'b0, GRP_BODY, CS_UNKNOWN, 24'd0, 24'd0, 1'b0, 1'b0},
        '{MODE_TORSO, 16'sd0, 16'sd0, 16'sd0, 16'd20,
          1'b1, GRP_TORSO, CS_UNKNOWN, 24'd0, 24'd0, 1'b0, 1'b0},
        '{MODE_TORSO, 16'sd0, 16'sd0, 16'sd0, 16'd20,
          1'b1, GRP_TORSO, CS_UNKNOWN, 24'd0, 24'd0, 1'b0, 1'b0},
        '{MODE_BODY_ORIENT, 16'sd5000, 16'sd0, 16'sd0, 16'd10,
          1'b0, GRP_BODY, CS_UNKNOWN, 24'd0, 24'd0, 1'b0, 1'b0},
        '{MODE_TORSO, 16'sd0, 16'sd0, 16'sd0, 16'd100,
          1'b1, GRP_TORSO, CS_CHANGED, 24'd0, 24'd0, 1'b0, 1'b0},
        '{MODE_TORSO, 16'sd0, 16'sd0, 16'sd0, 16'd100,
          1'b1, GRP_TORSO, CS_UNCHANGED, 24'd0, 24'd0, 1'b0, 1'b0},
        // head reaching the active minimum
        '{MODE_HEAD, 16'sd0, 16'sd0, 16'sd0, 16'd1,
          1'b1, GRP_HEAD, CS_UNKNOWN, 24'd0, 24'd0, 1'b0, 1'b0},
        '{MODE_HEAD, 16'sd0, 16'sd0, 16'sd0, 16'd1,
          1'b1, GRP_HEAD, CS_UNKNOWN, 24'd0, 24'd0, 1'b0, 1'b0},
        '{MODE_HEAD, 16'sd0, 16'sd0, 16'sd500, 16'd5,
          1'b1, GRP_HEAD, CS_CHANGED, 24'd0, 24'd0, 1'b0, 1'b0},
        '{MODE_HEAD, 16'sd0, 16'sd0, 16'sd1000, 16'd1000,
          1'b1, GRP_HEAD, CS_CHANGED, 24'd1000, 24'd0, 1'b1, 1'b0},
        // hands
        '{MODE_RIGHT_HAND, 16'sd0, 16'sd0, 16'sd0, 16'd3,
          1'b1, GRP_RIGHT_HAND, CS_UNKNOWN, 24'd0, 24'd0, 1'b0, 1'b0},
        '{MODE_RIGHT_HAND, 16'sd0, 16'sd0, 16'sd0, 16'd3,
          1'b1, GRP_RIGHT_HAND, CS_UNKNOWN, 24'd0, 24'd0, 1'b0, 1'b0},
        '{MODE_RIGHT_HAND, 16'sd0, 16'sd300, 16'sd0, 16'd9,
          1'b1, GRP_RIGHT_HAND, CS_CHANGED, 24'd0, 24'd0, 1'b0, 1'b0},
        '{MODE_LEFT_HAND, -16'sd1, -16'sd1, -16'sd1, 16'd4,
          1'b1, GRP_LEFT_HAND, CS_UNKNOWN, 24'd0, 24'd0, 1'b0, 1'b0},
        '{MODE_LEFT_HAND, -16'sd1, -16'sd1, -16'sd1, 16'd4,
          1'b1, GRP_LEFT_HAND, CS_UNKNOWN, 24'd0, 24'd0, 1'b0, 1'b0}
    };

    logic clk;
    logic rst_n;

    pcpd_cfg_if cfg_ch ();
    pcpd_smp_if smp_ch ();
    pcpd_res_if res_ch ();

    pose_change_persistence_detector_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .smp   (smp_ch),
        .res   (res_ch)
    );

    // predictor copy of settings and state
    logic [TOL_BITS-1:0]         tol_of_chan [NUM_CHANNELS];
    logic [PERIOD_BITS-1:0]      need_active;
    logic [PERIOD_BITS-1:0]      need_idle;
    logic signed [AXIS_BITS-1:0] chan_axes [NUM_CHANNELS][3];
    logic [CNT_BITS-1:0]         chan_count [NUM_CHANNELS];
    logic [STATE_BITS-1:0]       grp_state [NUM_GROUPS];
    logic [PERIOD_BITS-1:0]      grp_active [NUM_GROUPS];
    logic [PERIOD_BITS-1:0]      grp_idle [NUM_GROUPS];
    logic                        turn_latch;

    pose_result_t verdict_q [$];
    pose_result_t head_verdict;
    int           mismatches;
    int           quiet_cycles;
    int           snd_idle_pct;
    int           rcv_stall_pct;
    int           hold_left;
    bit           hold_req;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [PERIOD_BITS-1:0] sat_sum(input logic [PERIOD_BITS-1:0] p,
                                                        input logic [ELAPSED_BITS-1:0] e);
        logic [PERIOD_BITS:0] t;
        t = (PERIOD_BITS+1)'(p) + (PERIOD_BITS+1)'(e);
        return t[PERIOD_BITS] ? '1 : t[PERIOD_BITS-1:0];
    endfunction

    // advance the predicted state by one sample item; 1 when it yields a result
    function automatic bit track_pose(input pose_sample_t s, output pose_result_t r);
        int                          ch;
        int                          diff;
        bit                          known;
        bit                          moved;
        logic [GROUP_BITS-1:0]       g;
        logic signed [AXIS_BITS-1:0] cur [3];
        r = '0;
        if (s.mode > MODE_LEFT_HAND)
            return 1'b0;
        ch = int'(s.mode);
        cur[0] = s.a;
        cur[1] = s.b;
        cur[2] = s.c;
        known = chan_count[ch] >= 2;
        moved = 1'b0;
        if (known)
        begin
            for (int i = 0; i < 3; i++)
            begin
                diff = int'(cur[i]) - int'(chan_axes[ch][i]);
                if (diff < 0)
                    diff = -diff;
                if (diff >= int'(tol_of_chan[ch]))
                    moved = 1'b1;
            end
        end
        else
            chan_count[ch] = chan_count[ch] + 1'b1;
        for (int i = 0; i < 3; i++)
            chan_axes[ch][i] = cur[i];

        // body orientation only feeds the torso latch
        if (s.mode == MODE_BODY_ORIENT)
        begin
            if (known && moved)
                turn_latch = 1'b1;
            return 1'b0;
        end
        if (s.mode == MODE_TORSO)
        begin
            moved = moved | turn_latch;
            turn_latch = 1'b0;
        end

        case (s.mode)
            MODE_BODY_POS:   g = GRP_BODY;
            MODE_TORSO:      g = GRP_TORSO;
            MODE_HEAD:       g = GRP_HEAD;
            MODE_RIGHT_HAND: g = GRP_RIGHT_HAND;
            default:         g = GRP_LEFT_HAND;
        endcase
        r.group = g;

        // warm-up gives unknown and clears the group
        if (!known)
        begin
            grp_state[g]  = CS_UNKNOWN;
            grp_active[g] = '0;
            grp_idle[g]   = '0;
            return 1'b1;
        end

        if (moved)
        begin
            grp_active[g] = (grp_state[g] == CS_CHANGED) ?
                            sat_sum(grp_active[g], s.elapsed) : '0;
            grp_idle[g]   = '0;
            grp_state[g]  = CS_CHANGED;
        end
        else
        begin
            grp_idle[g]   = (grp_state[g] == CS_UNCHANGED) ?
                            sat_sum(grp_idle[g], s.elapsed) : '0;
            grp_active[g] = '0;
            grp_state[g]  = CS_UNCHANGED;
        end
        r.change_state  = grp_state[g];
        r.active_period = grp_active[g];
        r.idle_period   = grp_idle[g];
        r.is_active     = moved && (grp_active[g] >= need_active);
        r.is_idle       = !moved && (grp_idle[g] >= need_idle);
        return 1'b1;
    endfunction

    function automatic void check_field(input string what, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            mismatches++;
        end
    endfunction

    // register write; valid stays up so writes can go back to back
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            CFG_BODY_POS_TOL:    tol_of_chan[MODE_BODY_POS]    = val[TOL_BITS-1:0];
            CFG_BODY_ORIENT_TOL: tol_of_chan[MODE_BODY_ORIENT] = val[TOL_BITS-1:0];
            CFG_TORSO_TOL:       tol_of_chan[MODE_TORSO]       = val[TOL_BITS-1:0];
            CFG_HEAD_TOL:        tol_of_chan[MODE_HEAD]        = val[TOL_BITS-1:0];
            CFG_HAND_TOL:
            begin
                tol_of_chan[MODE_RIGHT_HAND] = val[TOL_BITS-1:0];
                tol_of_chan[MODE_LEFT_HAND]  = val[TOL_BITS-1:0];
            end
            CFG_MIN_ACTIVE:      need_active = val[PERIOD_BITS-1:0];
            CFG_MIN_IDLE:        need_idle   = val[PERIOD_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input int unsigned body,
                                input int unsigned orient,
                                input int unsigned torso,
                                input int unsigned head,
                                input int unsigned hand,
                                input int unsigned act,
                                input int unsigned idl);
        write_reg(CFG_BODY_POS_TOL, CFG_DATA_BITS'(body));
        write_reg(CFG_BODY_ORIENT_TOL, CFG_DATA_BITS'(orient));
        write_reg(CFG_TORSO_TOL, CFG_DATA_BITS'(torso));
        write_reg(CFG_HEAD_TOL, CFG_DATA_BITS'(head));
        write_reg(CFG_HAND_TOL, CFG_DATA_BITS'(hand));
        write_reg(CFG_MIN_ACTIVE, CFG_DATA_BITS'(act));
        write_reg(CFG_MIN_IDLE, CFG_DATA_BITS'(idl));
        cfg_ch.valid <= 1'b0;
    endtask

    // offer one sample item, optionally after a random gap, and log its result
    task automatic send_sample(input pose_sample_t s, input bit typed,
                               input pose_result_t want);
        pose_result_t p;
        pose_result_t q_item;
        while ($urandom_range(99) < snd_idle_pct)
        begin
            smp_ch.valid <= 1'b0;
            @(posedge clk);
        end
        smp_ch.valid      <= 1'b1;
        smp_ch.mode       <= s.mode;
        smp_ch.axis_a     <= s.a;
        smp_ch.axis_b     <= s.b;
        smp_ch.axis_c     <= s.c;
        smp_ch.elapsed_ms <= s.elapsed;
        do
            @(posedge clk);
        while (!smp_ch.ready);
        if (track_pose(s, p))
        begin
            q_item = typed ? want : p;
            verdict_q.insert(verdict_q.size(), q_item);
        end
    endtask

    // stop offering, let every result come out, then let stragglers settle
    task automatic drain();
        smp_ch.valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);
    endtask

    // random item, mostly small moves around the stored sample
    task automatic make_sample(output pose_sample_t s);
        int                          pick;
        int                          ch;
        int                          t;
        int                          ax;
        int                          step;
        logic signed [AXIS_BITS-1:0] v [3];
        pick = $urandom_range(99);
        ch = $urandom_range(NUM_CHANNELS - 1);
        if (pick < 4)
            s.mode = MODE_BITS'($urandom_range(MODE_UNUSED_HI, MODE_UNUSED_LO));
        else
            s.mode = ch[MODE_BITS-1:0];

        case ($urandom_range(19))
            0:       s.elapsed = '1;
            1, 2, 3: s.elapsed = ELAPSED_BITS'($urandom_range(65535));
            default: s.elapsed = ELAPSED_BITS'($urandom_range(2000));
        endcase

        if (pick < 12)
        begin
            for (int i = 0; i < 3; i++)
                v[i] = AXIS_BITS'($urandom);
        end
        else
        begin
            for (int i = 0; i < 3; i++)
                v[i] = chan_axes[ch][i];
            t = int'(tol_of_chan[ch]);
            ax = $urandom_range(2);
            case ($urandom_range(2))
                // same pose again
                0: ;
                // one axis right at the tolerance edge
                1:
                begin
                    step = t - 1 + int'($urandom_range(2));
                    if ($urandom_range(1))
                        step = -step;
                    v[ax] = AXIS_BITS'(int'(v[ax]) + step);
                end
                // jitter on every axis
                default:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        step = int'($urandom_range(2 * t + 2)) - t - 1;
                        v[i] = AXIS_BITS'(int'(v[i]) + step);
                    end
                end
            endcase
        end
        s.a = v[0];
        s.b = v[1];
        s.c = v[2];
    endtask

    task automatic run_random(input int n);
        pose_sample_t s;
        int           done;
        done = 0;
        while (done < n)
        begin
            make_sample(s);
            send_sample(s, 1'b0, '0);
            if (s.mode <= MODE_LEFT_HAND)
                done++;
        end
    endtask

    // result side: random stalls plus an occasional long hold-off
    initial
    begin
        res_ch.ready = 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    // compare each result item with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (verdict_q.size() == 0)
            begin
                $display("%0t: result item with nothing expected, group %0d",
                         $time, res_ch.group);
                mismatches++;
            end
            else
            begin
                head_verdict = verdict_q.pop_front();
                check_field("group", 32'(head_verdict.group), 32'(res_ch.group));
                check_field("change_state", 32'(head_verdict.change_state),
                            32'(res_ch.change_state));
                check_field("active_period", 32'(head_verdict.active_period),
                            32'(res_ch.active_period));
                check_field("idle_period", 32'(head_verdict.idle_period),
                            32'(res_ch.idle_period));
                check_field("is_active", 32'(head_verdict.is_active), 32'(res_ch.is_active));
                check_field("is_idle", 32'(head_verdict.is_idle), 32'(res_ch.is_idle));
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if (!rst_n || (smp_ch.valid && smp_ch.ready) || (res_ch.valid && res_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // stimulus
    initial
    begin
        pose_sample_t s;
        pose_result_t want;

        rst_n = 1'b0;
        mismatches = 0;
        snd_idle_pct = 0;
        rcv_stall_pct = 0;
        hold_req = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_BODY_POS_TOL;
        cfg_ch.data = '0;
        smp_ch.valid = 1'b0;
        smp_ch.mode = MODE_BODY_POS;
        smp_ch.axis_a = '0;
        smp_ch.axis_b = '0;
        smp_ch.axis_c = '0;
        smp_ch.elapsed_ms = '0;

        // predictor starts from the reset settings and empty storage
        tol_of_chan[MODE_BODY_POS]    = RST_BODY_POS_TOL;
        tol_of_chan[MODE_BODY_ORIENT] = RST_BODY_ORIENT_TOL;
        tol_of_chan[MODE_TORSO]       = RST_TORSO_TOL;
        tol_of_chan[MODE_HEAD]        = RST_HEAD_TOL;
        tol_of_chan[MODE_RIGHT_HAND]  = RST_HAND_TOL;
        tol_of_chan[MODE_LEFT_HAND]   = RST_HAND_TOL;
        need_active = RST_MIN_ACTIVE;
        need_idle = RST_MIN_IDLE;
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            chan_count[i] = '0;
            for (int j = 0; j < 3; j++)
                chan_axes[i][j] = '0;
        end
        for (int i = 0; i < NUM_GROUPS; i++)
        begin
            grp_state[i] = CS_UNKNOWN;
            grp_active[i] = '0;
            grp_idle[i] = '0;
        end
        turn_latch = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table under reset settings
        foreach (dir_rows[k])
        begin
            s.mode = dir_rows[k].mode;
            s.a = dir_rows[k].a;
            s.b = dir_rows[k].b;
            s.c = dir_rows[k].c;
            s.elapsed = dir_rows[k].elapsed;
            want.group = dir_rows[k].group;
            want.change_state = dir_rows[k].cs;
            want.active_period = dir_rows[k].act;
            want.idle_period = dir_rows[k].idl;
            want.is_active = dir_rows[k].ia;
            want.is_idle = dir_rows[k].ii;
            send_sample(s, dir_rows[k].typed, want);
        end
        drain();

        // moderate settings, no idling
        program_regs($urandom_range(1500), $urandom_range(1500), $urandom_range(1500),
                     $urandom_range(1500), $urandom_range(1500),
                     $urandom_range(3000), $urandom_range(3000));
        run_random(20);
        drain();

        // tolerance extremes and zero minimums, sender mostly idle
        snd_idle_pct = 76;
        program_regs(0, 'hFFFFFF, 0, 'hFFFFFF, 0, 0, 0);
        run_random(20);
        drain();

        // every data bit random, receiver mostly stalling
        snd_idle_pct = 0;
        rcv_stall_pct = 76;
        program_regs($urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom_range(4000), $urandom_range(4000));
        run_random(20);
        drain();

        // long hold-off on results while items keep coming
        rcv_stall_pct = 0;
        program_regs($urandom_range(600), $urandom_range(600), $urandom_range(600),
                     $urandom_range(600), $urandom_range(600),
                     $urandom_range(2000), $urandom_range(2000));
        hold_req = 1'b1;
        run_random(20);
        drain();

        // both sides idling a little
        snd_idle_pct = 18;
        rcv_stall_pct = 18;
        program_regs($urandom_range(800), $urandom_range(800), $urandom_range(800),
                     $urandom_range(800), $urandom_range(800),
                     $urandom_range(4000), $urandom_range(4000));
        run_random(20);
        drain();

        // saturation: head always changed, maximum minimums
        program_regs(500, 500, 500, 0, 'h7FFF, 'hFFFFFF, 'hFFFFFF);
        for (int k = 0; k < SAT_ROUNDS; k++)
        begin
            s.mode = MODE_HEAD;
            s.a = AXIS_BITS'($urandom);
            s.b = AXIS_BITS'($urandom);
            s.c = AXIS_BITS'($urandom);
            s.elapsed = ELAPSED_BITS'($urandom_range(65535, 65500));
            send_sample(s, 1'b0, '0);
        end
        drain();

        // tight tolerances, flags from the first known item
        snd_idle_pct = 0;
        rcv_stall_pct = 76;
        program_regs($urandom_range(40), $urandom_range(40), $urandom_range(40),
                     $urandom_range(40), $urandom_range(40), 0, 0);
        run_random(20);

        // wind down
        smp_ch.valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);
        if (verdict_q.size() != 0)
        begin
            $display("%0t: %0d expected result items never came", $time, verdict_q.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### sim.f
src/pcpd_pkg.sv
src/pcpd_if.sv
src/pcpd_ram.sv
src/pose_change_persistence_detector_core.sv
tb/sv/tb.sv
